@@ rtl/core/ort_pkg.sv @@
`timescale 1ns / 1ps
// ort_pkg: shared types and constants of the observer registration table
// used by the channel interfaces and by observer_registration_table

package ort_pkg;

    localparam int ADDR_W   = 64;
    localparam int PORT_W   = 16;
    localparam int TOKEN_W  = 64;
    localparam int TLEN_W   = 4;
    localparam int SEQ_W    = 24;
    localparam int SLOTID_W = 2;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_NOTIFY = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_ALREADY  = 4'd0,
        ST_REREG    = 4'd1,
        ST_ADDED    = 4'd2,
        ST_FULL     = 4'd3,
        ST_REMOVED  = 4'd4,
        ST_NOTFOUND = 4'd5,
        ST_NOTIFY   = 4'd6,
        ST_NONE     = 4'd7,
        ST_SEQFOUND = 4'd8,
        ST_SEQZERO  = 4'd9
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_NOTIFY,
        S_OUT
    } t_state;

endpackage

@@ rtl/core/ort_ifs.sv @@
`timescale 1ns / 1ps
// ort_req_if and ort_rsp_if: valid/ready channels of the observer table
// depends on ort_pkg for field types and widths

interface ort_req_if import ort_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_op                  operation;
    logic [ADDR_W-1:0]    addr_hi;
    logic [ADDR_W-1:0]    addr_lo;
    logic [PORT_W-1:0]    udp_port;
    logic [TOKEN_W-1:0]   token_bytes;
    logic [TLEN_W-1:0]    token_length;

    modport source (output valid, operation, addr_hi, addr_lo, udp_port,
                    token_bytes, token_length, input ready);
    modport sink   (input valid, operation, addr_hi, addr_lo, udp_port,
                    token_bytes, token_length, output ready);
endinterface

interface ort_rsp_if import ort_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_status              status;
    logic [SLOTID_W-1:0]  slot_index;
    logic [ADDR_W-1:0]    out_addr_hi;
    logic [ADDR_W-1:0]    out_addr_lo;
    logic [PORT_W-1:0]    out_port;
    logic [TOKEN_W-1:0]   out_token;
    logic [TLEN_W-1:0]    out_token_length;
    logic [SEQ_W-1:0]     sequence_res;
    logic                 last;

    modport source (output valid, status, slot_index, out_addr_hi, out_addr_lo,
                    out_port, out_token, out_token_length, sequence_res, last,
                    input ready);
    modport sink   (input valid, status, slot_index, out_addr_hi, out_addr_lo,
                    out_port, out_token, out_token_length, sequence_res, last,
                    output ready);
endinterface

@@ rtl/core/observer_registration_table.sv @@
`timescale 1ns / 1ps
// observer_registration_table: slot table of observers with add, remove,
// notify-all and sequence query; depends on ort_pkg and ort_ifs
//
//   channel   dir   carries
//   i_req     in    operation, peer address, port, token, token length
//   o_rsp     out   status, slot, notified peer fields, sequence, last
//
// add, remove and query walk the slots one per cycle through one shared
// compare unit, then a resolve step registers the result that is offered,
// and i_req is ready again the cycle after it goes.
// notify walks the slots with the shared incrementer up to the last active one and
// offers a result per active slot, moving on once it goes; i_req is low until the
// last result goes. synchronous active-low reset clears control state and active bits.

module observer_registration_table import ort_pkg::*; #(
    parameter int SLOTS           = 4,
    parameter int TOKEN_MAX_BYTES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ort_req_if.sink    i_req,
    ort_rsp_if.source  o_rsp
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // slot storage, data valid only where the active bit is set
    logic [SLOTS-1:0]   r_active;
    logic [ADDR_W-1:0]  r_slot_addr_hi [SLOTS];
    logic [ADDR_W-1:0]  r_slot_addr_lo [SLOTS];
    logic [PORT_W-1:0]  r_slot_port    [SLOTS];
    logic [TOKEN_W-1:0] r_slot_token   [SLOTS];
    logic [TLEN_W-1:0]  r_slot_tlen    [SLOTS];
    logic [SEQ_W-1:0]   r_slot_seq     [SLOTS];

    t_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic r_more, n_more;

    // captured request
    t_op                r_op;
    logic [ADDR_W-1:0]  r_hi, r_lo;
    logic [PORT_W-1:0]  r_port;
    logic [TOKEN_W-1:0] r_tok;
    logic [TLEN_W-1:0]  r_len;

    // scan results: a = exact (or query) match, b = same peer, c = free slot
    logic r_a_hit, n_a_hit, r_b_hit, n_b_hit, r_c_hit, n_c_hit;
    logic [IW-1:0] r_a_idx, n_a_idx, r_b_idx, n_b_idx, r_c_idx, n_c_idx;
    logic [SEQ_W-1:0] r_a_seq, n_a_seq;

    // result register
    t_status              r_o_status, n_o_status;
    logic [SLOTID_W-1:0]  r_o_slot, n_o_slot;
    logic [ADDR_W-1:0]    r_o_hi, n_o_hi, r_o_lo, n_o_lo;
    logic [PORT_W-1:0]    r_o_port, n_o_port;
    logic [TOKEN_W-1:0]   r_o_tok, n_o_tok;
    logic [TLEN_W-1:0]    r_o_len, n_o_len;
    logic [SEQ_W-1:0]     r_o_seq, n_o_seq;
    logic                 r_o_last, n_o_last;
    logic                 ld_out;

    // slot write controls
    logic             wr_en, wr_peer, wr_seq, act_set, act_clr;
    logic [IW-1:0]    wr_idx;
    logic [SEQ_W-1:0] wr_seq_val;

    // request token after clamping and masking
    logic [TLEN_W-1:0]  in_len;
    logic [TOKEN_W-1:0] in_mask;

    // shared compare and increment
    logic             cur_act, addr_eq, port_eq, tok_eq, later_act;
    logic [SEQ_W-1:0] seq_inc;

    always_comb begin
        in_len = (i_req.token_length > TLEN_W'(TOKEN_MAX_BYTES))
               ? TLEN_W'(TOKEN_MAX_BYTES) : i_req.token_length;
        for (int b = 0; b < TOKEN_W / 8; b++) begin
            in_mask[TOKEN_W-1-8*b -: 8] = (TLEN_W'(b) < in_len) ? 8'hFF : 8'h00;
        end
    end

    always_comb begin
        cur_act = r_active[r_idx];
        addr_eq = (r_slot_addr_hi[r_idx] == r_hi) && (r_slot_addr_lo[r_idx] == r_lo);
        port_eq = (r_slot_port[r_idx] == r_port);
        // stored tokens are masked to their own length, so whole-word compare
        tok_eq  = (r_slot_tlen[r_idx] == r_len) && (r_slot_token[r_idx] == r_tok);
        seq_inc = r_slot_seq[r_idx] + SEQ_W'(1);
        later_act = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (IW'(j) > r_idx && r_active[j]) begin
                later_act = 1'b1;
            end
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.status           = r_o_status;
    assign o_rsp.slot_index       = r_o_slot;
    assign o_rsp.out_addr_hi      = r_o_hi;
    assign o_rsp.out_addr_lo      = r_o_lo;
    assign o_rsp.out_port         = r_o_port;
    assign o_rsp.out_token        = r_o_tok;
    assign o_rsp.out_token_length = r_o_len;
    assign o_rsp.sequence_res     = r_o_seq;
    assign o_rsp.last             = r_o_last;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_more  = r_more;
        n_a_hit = r_a_hit;  n_a_idx = r_a_idx;  n_a_seq = r_a_seq;
        n_b_hit = r_b_hit;  n_b_idx = r_b_idx;
        n_c_hit = r_c_hit;  n_c_idx = r_c_idx;
        ld_out     = 1'b0;
        n_o_status = ST_NONE;
        n_o_slot   = '0;
        n_o_hi     = '0;
        n_o_lo     = '0;
        n_o_port   = '0;
        n_o_tok    = '0;
        n_o_len    = '0;
        n_o_seq    = '0;
        n_o_last   = 1'b1;
        wr_en      = 1'b0;
        wr_peer    = 1'b0;
        wr_seq     = 1'b0;
        act_set    = 1'b0;
        act_clr    = 1'b0;
        wr_idx     = r_idx;
        wr_seq_val = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_idx   = '0;
                    n_a_hit = 1'b0;
                    n_b_hit = 1'b0;
                    n_c_hit = 1'b0;
                    if (i_req.operation == OP_NOTIFY) begin
                        if (|r_active) begin
                            n_state = S_NOTIFY;
                        end else begin
                            ld_out     = 1'b1;
                            n_o_status = ST_NONE;
                            n_more     = 1'b0;
                            n_state    = S_OUT;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!r_a_hit && cur_act && addr_eq && tok_eq
                        && (port_eq || r_op == OP_QUERY)) begin
                    n_a_hit = 1'b1;
                    n_a_idx = r_idx;
                    n_a_seq = r_slot_seq[r_idx];
                end
                if (!r_b_hit && cur_act && addr_eq && port_eq) begin
                    n_b_hit = 1'b1;
                    n_b_idx = r_idx;
                end
                if (!r_c_hit && !cur_act) begin
                    n_c_hit = 1'b1;
                    n_c_idx = r_idx;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_RESOLVE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_RESOLVE: begin
                ld_out  = 1'b1;
                n_more  = 1'b0;
                n_state = S_OUT;
                unique case (r_op)
                    OP_ADD: begin
                        priority if (r_a_hit) begin
                            n_o_status = ST_ALREADY;
                            n_o_slot   = SLOTID_W'(r_a_idx);
                        end else if (r_b_hit) begin
                            wr_en      = 1'b1;
                            wr_seq     = 1'b1;
                            wr_idx     = r_b_idx;
                            n_o_status = ST_REREG;
                            n_o_slot   = SLOTID_W'(r_b_idx);
                        end else if (r_c_hit) begin
                            wr_en      = 1'b1;
                            wr_peer    = 1'b1;
                            wr_seq     = 1'b1;
                            act_set    = 1'b1;
                            wr_idx     = r_c_idx;
                            n_o_status = ST_ADDED;
                            n_o_slot   = SLOTID_W'(r_c_idx);
                        end else begin
                            n_o_status = ST_FULL;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_a_hit) begin
                            act_clr    = 1'b1;
                            wr_idx     = r_a_idx;
                            n_o_status = ST_REMOVED;
                            n_o_slot   = SLOTID_W'(r_a_idx);
                        end else begin
                            n_o_status = ST_NOTFOUND;
                        end
                    end
                    OP_QUERY: begin
                        if (r_a_hit) begin
                            n_o_status = ST_SEQFOUND;
                            n_o_slot   = SLOTID_W'(r_a_idx);
                            n_o_seq    = r_a_seq;
                        end else begin
                            n_o_status = ST_SEQZERO;
                        end
                    end
                    default: begin
                        n_o_status = ST_NONE;
                    end
                endcase
            end
            S_NOTIFY: begin
                if (cur_act) begin
                    wr_seq     = 1'b1;
                    wr_seq_val = seq_inc;
                    ld_out     = 1'b1;
                    n_o_status = ST_NOTIFY;
                    n_o_slot   = SLOTID_W'(r_idx);
                    n_o_hi     = r_slot_addr_hi[r_idx];
                    n_o_lo     = r_slot_addr_lo[r_idx];
                    n_o_port   = r_slot_port[r_idx];
                    n_o_tok    = r_slot_token[r_idx];
                    n_o_len    = r_slot_tlen[r_idx];
                    n_o_seq    = seq_inc;
                    n_o_last   = !later_act;
                    n_more     = later_act;
                    n_state    = S_OUT;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    if (r_more) begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_NOTIFY;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_more   <= 1'b0;
            r_active <= '0;
            r_a_hit  <= 1'b0;
            r_b_hit  <= 1'b0;
            r_c_hit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_more  <= n_more;
            r_a_hit <= n_a_hit;
            r_b_hit <= n_b_hit;
            r_c_hit <= n_c_hit;
            if (act_set) begin
                r_active[wr_idx] <= 1'b1;
            end
            if (act_clr) begin
                r_active[wr_idx] <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_a_idx <= n_a_idx;
        r_a_seq <= n_a_seq;
        r_b_idx <= n_b_idx;
        r_c_idx <= n_c_idx;
        if (i_req.valid && i_req.ready) begin
            r_op   <= i_req.operation;
            r_hi   <= i_req.addr_hi;
            r_lo   <= i_req.addr_lo;
            r_port <= i_req.udp_port;
            r_tok  <= i_req.token_bytes & in_mask;
            r_len  <= in_len;
        end
        if (ld_out) begin
            r_o_status <= n_o_status;
            r_o_slot   <= n_o_slot;
            r_o_hi     <= n_o_hi;
            r_o_lo     <= n_o_lo;
            r_o_port   <= n_o_port;
            r_o_tok    <= n_o_tok;
            r_o_len    <= n_o_len;
            r_o_seq    <= n_o_seq;
            r_o_last   <= n_o_last;
        end
        if (wr_en) begin
            r_slot_token[wr_idx] <= r_tok;
            r_slot_tlen[wr_idx]  <= r_len;
        end
        if (wr_en && wr_peer) begin
            r_slot_addr_hi[wr_idx] <= r_hi;
            r_slot_addr_lo[wr_idx] <= r_lo;
            r_slot_port[wr_idx]    <= r_port;
        end
        if (wr_seq) begin
            r_slot_seq[wr_idx] <= wr_seq_val;
        end
    end

endmodule

@@ tb/ort_checker.sv @@
`timescale 1ns / 1ps
// ort_checker: watches the request and response channels of the observer table,
// predicts every response from its own copy of the slots and compares field by field
// depends on ort_pkg and the channel interfaces in ort_ifs

module ort_checker import ort_pkg::*; #(
    parameter int SLOTS           = 4,
    parameter int TOKEN_MAX_BYTES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ort_req_if   i_req,
    ort_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_compared
);

    typedef struct {
        t_status               status;
        logic [SLOTID_W-1:0]   slot_index;
        logic [ADDR_W-1:0]     addr_hi;
        logic [ADDR_W-1:0]     addr_lo;
        logic [PORT_W-1:0]     port;
        logic [TOKEN_W-1:0]    token;
        logic [TLEN_W-1:0]     token_length;
        logic [SEQ_W-1:0]      seq;
        logic                  last;
    } t_rsp_exp;

    logic                 slot_on   [SLOTS];
    logic [ADDR_W-1:0]    slot_hi   [SLOTS];
    logic [ADDR_W-1:0]    slot_lo   [SLOTS];
    logic [PORT_W-1:0]    slot_port [SLOTS];
    logic [TOKEN_W-1:0]   slot_tok  [SLOTS];
    logic [TLEN_W-1:0]    slot_len  [SLOTS];
    logic [SEQ_W-1:0]     slot_seq  [SLOTS];

    t_rsp_exp due_rsp[$];
    int       fails    = 0;
    int       compared = 0;

    assign o_fail_count = fails;
    assign o_compared   = compared;

    function automatic logic [TOKEN_W-1:0] byte_mask(input int unsigned len);
        if (len == 0) return '0;
        return {TOKEN_W{1'b1}} << (TOKEN_W - 8 * len);
    endfunction

    function automatic bit token_same(input int i, input logic [TOKEN_W-1:0] tok,
                                      input int unsigned len);
        return slot_len[i] == TLEN_W'(len) && (slot_tok[i] & byte_mask(len)) == tok;
    endfunction

    function automatic bit addr_same(input int i, input logic [ADDR_W-1:0] hi,
                                     input logic [ADDR_W-1:0] lo);
        return slot_hi[i] == hi && slot_lo[i] == lo;
    endfunction

    // first active slot with address, port and token all equal, or -1
    function automatic int exact_slot(input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo,
                                      input logic [PORT_W-1:0] port,
                                      input logic [TOKEN_W-1:0] tok, input int unsigned len);
        for (int i = 0; i < SLOTS; i++)
            if (slot_on[i] && addr_same(i, hi, lo) && slot_port[i] == port &&
                token_same(i, tok, len))
                return i;
        return -1;
    endfunction

    function automatic t_rsp_exp plain_rsp(input t_status st, input int slot,
                                           input logic [SEQ_W-1:0] seq);
        t_rsp_exp r;
        r.status       = st;
        r.slot_index   = SLOTID_W'(slot);
        r.addr_hi      = '0;
        r.addr_lo      = '0;
        r.port         = '0;
        r.token        = '0;
        r.token_length = '0;
        r.seq          = seq;
        r.last         = 1'b1;
        return r;
    endfunction

    // updates the slot copy for one request and queues the responses it causes
    task automatic table_apply(input t_op op, input logic [ADDR_W-1:0] hi,
                               input logic [ADDR_W-1:0] lo, input logic [PORT_W-1:0] port,
                               input logic [TOKEN_W-1:0] tok_in,
                               input logic [TLEN_W-1:0] len_in);
        int unsigned        len;
        logic [TOKEN_W-1:0] tok;
        int                 hit;
        int                 final_slot;
        t_rsp_exp           r;
        len = (len_in > TOKEN_MAX_BYTES) ? TOKEN_MAX_BYTES : len_in;
        tok = tok_in & byte_mask(len);
        hit = -1;
        case (op)
            OP_ADD: begin
                hit = exact_slot(hi, lo, port, tok, len);
                if (hit >= 0) begin
                    due_rsp.push_back(plain_rsp(ST_ALREADY, hit, '0));
                end else begin
                    for (int i = 0; i < SLOTS; i++)
                        if (hit < 0 && slot_on[i] && addr_same(i, hi, lo) && slot_port[i] == port)
                            hit = i;
                    if (hit >= 0) begin
                        slot_tok[hit] = tok;
                        slot_len[hit] = TLEN_W'(len);
                        slot_seq[hit] = '0;
                        due_rsp.push_back(plain_rsp(ST_REREG, hit, '0));
                    end else begin
                        for (int i = 0; i < SLOTS; i++)
                            if (hit < 0 && !slot_on[i]) hit = i;
                        if (hit >= 0) begin
                            slot_on[hit]   = 1'b1;
                            slot_hi[hit]   = hi;
                            slot_lo[hit]   = lo;
                            slot_port[hit] = port;
                            slot_tok[hit]  = tok;
                            slot_len[hit]  = TLEN_W'(len);
                            slot_seq[hit]  = '0;
                            due_rsp.push_back(plain_rsp(ST_ADDED, hit, '0));
                        end else begin
                            due_rsp.push_back(plain_rsp(ST_FULL, 0, '0));
                        end
                    end
                end
            end
            OP_REMOVE: begin
                hit = exact_slot(hi, lo, port, tok, len);
                if (hit >= 0) begin
                    slot_on[hit] = 1'b0;
                    due_rsp.push_back(plain_rsp(ST_REMOVED, hit, '0));
                end else begin
                    due_rsp.push_back(plain_rsp(ST_NOTFOUND, 0, '0));
                end
            end
            OP_NOTIFY: begin
                final_slot = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_on[i]) final_slot = i;
                if (final_slot < 0) begin
                    due_rsp.push_back(plain_rsp(ST_NONE, 0, '0));
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_on[i]) begin
                            // 24-bit width gives the wrap to zero
                            slot_seq[i]    = slot_seq[i] + 1'b1;
                            r              = plain_rsp(ST_NOTIFY, i, slot_seq[i]);
                            r.addr_hi      = slot_hi[i];
                            r.addr_lo      = slot_lo[i];
                            r.port         = slot_port[i];
                            r.token        = slot_tok[i];
                            r.token_length = slot_len[i];
                            r.last         = (i == final_slot);
                            due_rsp.push_back(r);
                        end
                    end
                end
            end
            default: begin
                // port plays no part in the lookup
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && slot_on[i] && token_same(i, tok, len) && addr_same(i, hi, lo))
                        hit = i;
                if (hit >= 0) due_rsp.push_back(plain_rsp(ST_SEQFOUND, hit, slot_seq[hit]));
                else due_rsp.push_back(plain_rsp(ST_SEQZERO, 0, '0));
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rsp_exp e;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) slot_on[i] = 1'b0;
            due_rsp.delete();
        end else begin
            // response first: it belongs to an earlier request than one taken this edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_rsp.size() == 0) begin
                    $error("response with nothing outstanding: status %0d slot %0d",
                           i_rsp.status, i_rsp.slot_index);
                    fails++;
                end else begin
                    e = due_rsp.pop_front();
                    compared++;
                    check_field("status", e.status, i_rsp.status);
                    check_field("slot_index", e.slot_index, i_rsp.slot_index);
                    check_field("out_addr_hi", e.addr_hi, i_rsp.out_addr_hi);
                    check_field("out_addr_lo", e.addr_lo, i_rsp.out_addr_lo);
                    check_field("out_port", e.port, i_rsp.out_port);
                    check_field("out_token", e.token, i_rsp.out_token);
                    check_field("out_token_length", e.token_length, i_rsp.out_token_length);
                    check_field("sequence_res", e.seq, i_rsp.sequence_res);
                    check_field("last", e.last, i_rsp.last);
                end
            end
            if (i_req.valid && i_req.ready)
                table_apply(i_req.operation, i_req.addr_hi, i_req.addr_lo, i_req.udp_port,
                            i_req.token_bytes, i_req.token_length);
        end
        o_pending = due_rsp.size();
    end

endmodule

@@ tb/observer_registration_table_tb.sv @@
`timescale 1ns / 1ps
// observer_registration_table_tb: directed and random requests against the observer
// table under several throttle mixes; depends on ort_pkg, ort_ifs and ort_checker

module observer_registration_table_tb;
    import ort_pkg::*;

    localparam int SLOTS        = 4;
    localparam int TOKEN_MAX    = 8;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 8;
    localparam int PEERS        = 6;
    localparam int PHASE_ITEMS  = 16;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    localparam int SEND_IDLE_PCT [4] = '{0, 61, 0, 22};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 61, 22};

    typedef struct {
        logic [ADDR_W-1:0]  hi;
        logic [ADDR_W-1:0]  lo;
        logic [PORT_W-1:0]  port;
        logic [TOKEN_W-1:0] tok;
        logic [TLEN_W-1:0]  len;
    } t_peer;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int fail_count;
    int pending;
    int compared;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_reqs  = 0;
    int hold_done  = 0;
    int hold_left  = 0;
    int quiet      = 0;
    int sent_count [4] = '{0, 0, 0, 0};

    t_peer peers[PEERS];

    ort_req_if req_ch ();
    ort_rsp_if rsp_ch ();

    observer_registration_table #(
        .SLOTS           (SLOTS),
        .TOKEN_MAX_BYTES (TOKEN_MAX)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    ort_checker #(
        .SLOTS           (SLOTS),
        .TOKEN_MAX_BYTES (TOKEN_MAX)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_compared   (compared)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // response side: random stalls, or a long hold counted here when one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_reqs != hold_done) begin
            rsp_ch.ready <= 1'b0;
            hold_done    <= hold_done + 1;
            hold_left    <= LONG_HOLD;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TOKEN_W-1:0] keep_bytes(input int unsigned len);
        if (len == 0) return '0;
        if (len > TOKEN_MAX) len = TOKEN_MAX;
        return {TOKEN_W{1'b1}} << (TOKEN_W - 8 * len);
    endfunction

    // called at a rising edge, returns at the rising edge where the item was taken
    task automatic send_item(input t_op op, input logic [ADDR_W-1:0] hi,
                             input logic [ADDR_W-1:0] lo, input logic [PORT_W-1:0] port,
                             input logic [TOKEN_W-1:0] tok, input logic [TLEN_W-1:0] len);
        logic took;
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.addr_hi      <= hi;
        req_ch.addr_lo      <= lo;
        req_ch.udp_port     <= port;
        req_ch.token_bytes  <= tok;
        req_ch.token_length <= len;
        do begin
            @(negedge i_clk);
            took = req_ch.ready;
            @(posedge i_clk);
        end while (!took);
        sent_count[op]++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // mostly requests from a small peer pool so that matches, refreshes and a full table occur
    task automatic random_item();
        t_peer              p;
        int                 pick;
        t_op                op;
        logic [PORT_W-1:0]  port;
        logic [TOKEN_W-1:0] tok;
        logic [TLEN_W-1:0]  len;
        p    = peers[$urandom_range(PEERS - 1)];
        port = p.port;
        tok  = p.tok;
        len  = p.len;
        if ($urandom_range(1) == 1) tok = tok | (rand64() & ~keep_bytes(len));
        if (len == TOKEN_MAX && $urandom_range(3) == 0)
            len = TLEN_W'($urandom_range(15, TOKEN_MAX + 1));
        pick = $urandom_range(99);
        if (pick < 35) begin
            op = OP_ADD;
            if ($urandom_range(5) == 0) begin
                tok = rand64();
                len = TLEN_W'($urandom_range(TOKEN_MAX));
            end
        end else if (pick < 55) begin
            op = OP_REMOVE;
        end else if (pick < 72) begin
            op = OP_NOTIFY;
        end else if (pick < 90) begin
            op = OP_QUERY;
            if ($urandom_range(2) == 0) port = PORT_W'($urandom);
        end else begin
            op   = t_op'($urandom_range(3));
            p.hi = rand64();
            p.lo = rand64();
            port = PORT_W'($urandom);
            tok  = rand64();
            len  = TLEN_W'($urandom_range(15));
        end
        send_item(op, p.hi, p.lo, port, tok, len);
    endtask

    initial begin
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_ADD;
        req_ch.addr_hi      = '0;
        req_ch.addr_lo      = '0;
        req_ch.udp_port     = '0;
        req_ch.token_bytes  = '0;
        req_ch.token_length = '0;

        for (int k = 0; k < PEERS; k++) begin
            peers[k].hi   = rand64();
            peers[k].lo   = rand64();
            peers[k].port = PORT_W'($urandom);
            peers[k].len  = TLEN_W'($urandom_range(TOKEN_MAX));
            peers[k].tok  = rand64() & keep_bytes(peers[k].len);
        end
        // same host on another port, and same host and port with another token
        peers[1].hi   = peers[0].hi;
        peers[1].lo   = peers[0].lo;
        peers[1].port = peers[0].port ^ 16'h0001;
        peers[3].hi   = peers[2].hi;
        peers[3].lo   = peers[2].lo;
        peers[3].port = peers[2].port;
        peers[3].len  = TLEN_W'((peers[2].len + 1) % (TOKEN_MAX + 1));
        peers[3].tok  = rand64() & keep_bytes(peers[3].len);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes of every field, each status
        send_item(OP_NOTIFY, '1, '1, '1, '1, 4'd8);
        send_item(OP_QUERY, '1, '1, '1, '1, 4'd8);
        send_item(OP_REMOVE, '1, '1, '1, '1, 4'd8);
        send_item(OP_ADD, '1, '1, '1, '1, 4'd8);
        send_item(OP_ADD, '1, '1, '1, '1, 4'd8);
        // zero-length token: every byte beyond the length is ignored
        send_item(OP_ADD, '0, '0, '0, 64'hDEAD_BEEF_CAFE_F00D, 4'd0);
        send_item(OP_ADD, '1, '1, '1, 64'h0123_4567_89AB_CDEF, 4'd3);
        send_item(OP_ADD, '1, '1, '1, 64'h0123_45FF_0000_1111, 4'd3);
        // length above the maximum is clamped
        send_item(OP_ADD, 64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555, 16'h8000,
                  '1, 4'd15);
        send_item(OP_ADD, '0, '0, 16'h0001, '0, 4'd1);
        send_item(OP_ADD, 64'h0F0F_0F0F_0F0F_0F0F, 64'hAAAA_AAAA_AAAA_AAAA, 16'h7FFF,
                  64'h1100_0000_0000_0000, 4'd1);
        send_item(OP_NOTIFY, '0, '0, '0, '0, 4'd0);
        send_item(OP_QUERY, '1, '1, '0, 64'h0123_4567_89AB_CDEF, 4'd3);
        send_item(OP_QUERY, 64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555, 16'h1234,
                  '1, 4'd8);
        send_item(OP_QUERY, '0, '0, '1, '1, 4'd0);
        send_item(OP_QUERY, '1, '1, '1, 64'h0123_4567_89AB_CDEF, 4'd2);
        send_item(OP_REMOVE, '0, '0, '0, '0, 4'd0);
        send_item(OP_REMOVE, '0, '0, '0, '0, 4'd0);
        // refresh resets the sequence, so the lookup finds zero
        send_item(OP_ADD, '1, '1, '1, '1, 4'd8);
        send_item(OP_QUERY, '1, '1, '1, '1, 4'd8);
        send_item(OP_NOTIFY, '1, '0, '1, '0, 4'd4);
        send_item(OP_ADD, '0, '0, '0, '0, 4'd0);
        send_item(OP_REMOVE, 64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555, 16'h8000,
                  '1, 4'd12);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = SEND_IDLE_PCT[ph];
            stall_pct <= RECV_STALL_PCT[ph];
            repeat (PHASE_ITEMS) random_item();
            wait_drained();
            if (ph == 0) begin
                // output held off while requests keep coming, then a full drain
                hold_reqs <= hold_reqs + 1;
                repeat (12) random_item();
                wait_drained();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d add, %0d remove, %0d notify, %0d query requests",
                 sent_count[OP_ADD], sent_count[OP_REMOVE], sent_count[OP_NOTIFY],
                 sent_count[OP_QUERY]);
        $display("%0d responses compared across four throttle mixes and a %0d-cycle output hold",
                 compared, LONG_HOLD);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ observer_registration_table.f @@
rtl/core/ort_pkg.sv
rtl/core/ort_ifs.sv
rtl/core/observer_registration_table.sv
tb/ort_checker.sv
tb/observer_registration_table_tb.sv
